FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property shorthands for the rmce checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RMCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmce check failed");

// next-cycle implication, disabled while reset is asserted
`define RMCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmce check failed");

`endif

FILE: hw/rtl/rmce_pkg.sv
// ----------------------------------------------------------------------------
// rmce_pkg
// types, register indexes and sequencer codes of the rsa mod-exp engine
// ----------------------------------------------------------------------------
package rmce_pkg;

    localparam int WORD_BITS    = 64;
    localparam int HALF_BITS    = 32;
    localparam int CNT_BITS     = $clog2(WORD_BITS);
    localparam int CFG_IDX_BITS = 3;

    typedef logic [WORD_BITS-1:0] rmce_word_t;
    typedef logic [HALF_BITS-1:0] rmce_half_t;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS_N = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIME_P   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIME_Q   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXP_MOD_P = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXP_MOD_Q = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_Q_INVERSE = 3'd6;

    // item commands
    localparam logic CMD_PLAIN = 1'b0;
    localparam logic CMD_CRT   = 1'b1;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_RED,
        OP_ADD
    } rmce_op_t;

    typedef struct packed {
        logic       start;
        rmce_op_t   op;
        rmce_word_t a;
        rmce_word_t b;
        rmce_word_t m;
    } rmce_req_t;

    typedef struct packed {
        logic       done;
        rmce_word_t result;
    } rmce_rsp_t;

    typedef struct packed {
        logic       command;
        rmce_word_t value_in;
    } rmce_item_t;

    typedef struct packed {
        rmce_word_t value_out;
        logic       error;
    } rmce_result_t;

    // which power is running
    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_P,
        PH_Q
    } rmce_phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_P,
        S_RED_Q,
        S_POW,
        S_POW_MUL,
        S_POW_SQR,
        S_RED_M1,
        S_RED_M2,
        S_DIFF,
        S_H,
        S_HQ,
        S_SUM,
        S_OUT
    } rmce_state_t;

endpackage

FILE: hw/rtl/rmce_arith.sv
// ----------------------------------------------------------------------------
// rmce_arith
// shared iterative modular unit: add-and-double multiply, restoring
// reduction and single modular add, one bit step per cycle
// ----------------------------------------------------------------------------
module rmce_arith import rmce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rmce_req_t req,
    output rmce_rsp_t rsp
);

    rmce_op_t              op_reg, op_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    rmce_word_t            acc_reg, acc_next;
    rmce_word_t            x_reg, x_next;
    rmce_word_t            y_reg, y_next;
    rmce_word_t            m_reg, m_next;

    logic [WORD_BITS:0]    sum;
    logic [WORD_BITS:0]    dbl;
    logic [WORD_BITS+1:0]  sum_diff;
    logic [WORD_BITS+1:0]  dbl_diff;
    rmce_word_t            sum_mod;
    rmce_word_t            dbl_mod;
    logic                  m_nz;
    logic                  last;

    // shared add / shift-in path, then one compare-subtract against m
    always_comb
    begin
        m_nz = (m_reg != '0);
        if (op_reg == OP_RED)
        begin
            sum = {acc_reg, y_reg[WORD_BITS-1]};
        end
        else
        begin
            sum = {1'b0, acc_reg} + {1'b0, x_reg};
        end
        sum_diff = {1'b0, sum} - {2'b00, m_reg};
        sum_mod  = (m_nz && !sum_diff[WORD_BITS+1]) ? sum_diff[WORD_BITS-1:0]
                                                     : sum[WORD_BITS-1:0];
        dbl      = {x_reg, 1'b0};
        dbl_diff = {1'b0, dbl} - {2'b00, m_reg};
        dbl_mod  = (m_nz && !dbl_diff[WORD_BITS+1]) ? dbl_diff[WORD_BITS-1:0]
                                                     : dbl[WORD_BITS-1:0];
        last     = (op_reg == OP_ADD) || (cnt_reg == CNT_BITS'(WORD_BITS - 1));
    end

    always_comb
    begin
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        m_next    = m_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = '0;
            m_next    = req.m;
            acc_next  = (req.op == OP_ADD) ? req.a : '0;
            x_next    = (req.op == OP_MUL) ? req.a : req.b;
            y_next    = (req.op == OP_MUL) ? req.b : req.a;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_next = sum_mod;
                    end
                    x_next = dbl_mod;
                    y_next = y_reg >> 1;
                end
                OP_RED:
                begin
                    acc_next = sum_mod;
                    y_next   = y_reg << 1;
                end
                OP_ADD:
                begin
                    acc_next = sum_mod;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_ADD;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

FILE: hw/rtl/rsa_modexp_crt_engine.sv
// ----------------------------------------------------------------------------
// rsa_modexp_crt_engine: 64-bit rsa power engine with a crt private path
// a range error skips the power; plain runs a product per set exponent bit
// and a square per bit below the top set one; crt runs the p and q powers
// with reductions and recombination on the shared unit, one op at a time
// throughput: one word at a time, next word taken once the result is queued
// reset: rst_n async low clears sequencer, output valid and all key registers
// ----------------------------------------------------------------------------
module rsa_modexp_crt_engine import rmce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input words
    input  logic                    item_valid,
    output logic                    item_stall,
    input  rmce_item_t              item,
    // result words
    output logic                    result_valid,
    input  logic                    result_stall,
    output rmce_result_t            result,
    // key register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  rmce_word_t              cfg_data
);

    // key registers
    rmce_word_t   modulus_n_reg;
    rmce_word_t   exponent_reg;
    rmce_half_t   prime_p_reg;
    rmce_half_t   prime_q_reg;
    rmce_half_t   exp_mod_p_reg;
    rmce_half_t   exp_mod_q_reg;
    rmce_half_t   q_inverse_reg;

    // sequencer and working registers
    rmce_state_t  state_reg, state_next;
    rmce_phase_t  phase_reg, phase_next;
    rmce_word_t   value_reg, value_next;   // input word kept for the q side
    rmce_word_t   base_reg, base_next;     // running square of the power
    rmce_word_t   pexp_reg, pexp_next;     // remaining exponent bits
    rmce_word_t   pacc_reg, pacc_next;     // power accumulator
    rmce_word_t   pmod_reg, pmod_next;     // modulus of the running power
    rmce_word_t   m1_reg, m1_next;
    rmce_word_t   m2_reg, m2_next;
    rmce_word_t   tmp_reg, tmp_next;       // final word waiting for the output

    // output register
    logic         result_valid_reg, result_valid_next;
    rmce_result_t result_reg, result_next;
    logic         out_load;

    // shared unit
    rmce_req_t    req;
    rmce_rsp_t    rsp;

    rmce_word_t   p_word;
    rmce_word_t   q_word;
    rmce_word_t   dp_word;
    rmce_word_t   dq_word;
    rmce_word_t   qinv_word;
    rmce_word_t   neg_m2;

    assign p_word    = {{(WORD_BITS-HALF_BITS){1'b0}}, prime_p_reg};
    assign q_word    = {{(WORD_BITS-HALF_BITS){1'b0}}, prime_q_reg};
    assign dp_word   = {{(WORD_BITS-HALF_BITS){1'b0}}, exp_mod_p_reg};
    assign dq_word   = {{(WORD_BITS-HALF_BITS){1'b0}}, exp_mod_q_reg};
    assign qinv_word = {{(WORD_BITS-HALF_BITS){1'b0}}, q_inverse_reg};

    // -(m2 mod p) mod p, so that m1 - m2 becomes one modular add;
    // with p zero this is plain two's complement and the add wraps
    assign neg_m2 = (rsp.result == '0) ? '0 : (p_word - rsp.result);

    rmce_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // key registers are only written while the engine is idle
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_n_reg <= '0;
            exponent_reg  <= '0;
            prime_p_reg   <= '0;
            prime_q_reg   <= '0;
            exp_mod_p_reg <= '0;
            exp_mod_q_reg <= '0;
            q_inverse_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODULUS_N: modulus_n_reg <= cfg_data;
                REG_EXPONENT:  exponent_reg  <= cfg_data;
                REG_PRIME_P:   prime_p_reg   <= cfg_data[HALF_BITS-1:0];
                REG_PRIME_Q:   prime_q_reg   <= cfg_data[HALF_BITS-1:0];
                REG_EXP_MOD_P: exp_mod_p_reg <= cfg_data[HALF_BITS-1:0];
                REG_EXP_MOD_Q: exp_mod_q_reg <= cfg_data[HALF_BITS-1:0];
                REG_Q_INVERSE: q_inverse_reg <= cfg_data[HALF_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // only the idle state takes a word; the output register decouples
    // the result side so a queued result does not block the next word
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        value_next = value_reg;
        base_next  = base_reg;
        pexp_next  = pexp_reg;
        pacc_next  = pacc_reg;
        pmod_next  = pmod_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        tmp_next   = tmp_reg;
        out_load   = 1'b0;
        req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.value_in >= modulus_n_reg)
                    begin
                        // range error: word goes back unchanged
                        tmp_next   = item.value_in;
                        state_next = S_OUT;
                    end
                    else if (item.command == CMD_PLAIN)
                    begin
                        // word is already below n
                        base_next  = item.value_in;
                        pexp_next  = exponent_reg;
                        pmod_next  = modulus_n_reg;
                        pacc_next  = rmce_word_t'(1);
                        phase_next = PH_PLAIN;
                        state_next = S_POW;
                    end
                    else
                    begin
                        value_next = item.value_in;
                        req.start  = 1'b1;
                        req.op     = OP_RED;
                        req.a      = item.value_in;
                        req.m      = p_word;
                        state_next = S_RED_P;
                    end
                end
            end

            S_RED_P:
            begin
                if (rsp.done)
                begin
                    base_next  = rsp.result;
                    pexp_next  = dp_word;
                    pmod_next  = p_word;
                    pacc_next  = rmce_word_t'(1);
                    phase_next = PH_P;
                    state_next = S_POW;
                end
            end

            S_RED_Q:
            begin
                if (rsp.done)
                begin
                    base_next  = rsp.result;
                    pexp_next  = dq_word;
                    pmod_next  = q_word;
                    pacc_next  = rmce_word_t'(1);
                    phase_next = PH_Q;
                    state_next = S_POW;
                end
            end

            // right-to-left square and multiply; a zero exponent leaves 1
            S_POW:
            begin
                if (pexp_reg == '0)
                begin
                    case (phase_reg)
                        PH_PLAIN:
                        begin
                            tmp_next   = pacc_reg;
                            state_next = S_OUT;
                        end
                        PH_P:
                        begin
                            m1_next    = pacc_reg;
                            req.start  = 1'b1;
                            req.op     = OP_RED;
                            req.a      = value_reg;
                            req.m      = q_word;
                            state_next = S_RED_Q;
                        end
                        PH_Q:
                        begin
                            m2_next    = pacc_reg;
                            req.start  = 1'b1;
                            req.op     = OP_RED;
                            req.a      = m1_reg;
                            req.m      = p_word;
                            state_next = S_RED_M1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else if (pexp_reg[0])
                begin
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = base_reg;
                    req.b      = pacc_reg;
                    req.m      = pmod_reg;
                    state_next = S_POW_MUL;
                end
                else
                begin
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = base_reg;
                    req.b      = base_reg;
                    req.m      = pmod_reg;
                    state_next = S_POW_SQR;
                end
            end

            S_POW_MUL:
            begin
                if (rsp.done)
                begin
                    pacc_next = rsp.result;
                    if (pexp_reg[WORD_BITS-1:1] == '0)
                    begin
                        // last set bit: the final square is never used
                        pexp_next  = '0;
                        state_next = S_POW;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        req.op     = OP_MUL;
                        req.a      = base_reg;
                        req.b      = base_reg;
                        req.m      = pmod_reg;
                        state_next = S_POW_SQR;
                    end
                end
            end

            S_POW_SQR:
            begin
                if (rsp.done)
                begin
                    base_next  = rsp.result;
                    pexp_next  = pexp_reg >> 1;
                    state_next = S_POW;
                end
            end

            S_RED_M1:
            begin
                if (rsp.done)
                begin
                    m1_next    = rsp.result;
                    req.start  = 1'b1;
                    req.op     = OP_RED;
                    req.a      = m2_reg;
                    req.m      = p_word;
                    state_next = S_RED_M2;
                end
            end

            // (m1 - m2) mod p
            S_RED_M2:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_ADD;
                    req.a      = m1_reg;
                    req.b      = neg_m2;
                    req.m      = p_word;
                    state_next = S_DIFF;
                end
            end

            // h = q_inverse * diff mod p, diff is the reduced operand
            S_DIFF:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = rsp.result;
                    req.b      = qinv_word;
                    req.m      = p_word;
                    state_next = S_H;
                end
            end

            // h * q, wrapping at the word width
            S_H:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = rsp.result;
                    req.b      = q_word;
                    req.m      = '0;
                    state_next = S_HQ;
                end
            end

            // m2 + h * q, wrapping
            S_HQ:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_ADD;
                    req.a      = m2_reg;
                    req.b      = rsp.result;
                    req.m      = '0;
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                if (rsp.done)
                begin
                    tmp_next   = rsp.result;
                    state_next = S_OUT;
                end
            end

            // wait for a free output register
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register; error covers both the range check and a result >= n
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_next.value_out = tmp_reg;
            result_next.error     = (tmp_reg >= modulus_n_reg);
            result_valid_next     = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_PLAIN;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        base_reg   <= base_next;
        pexp_reg   <= pexp_next;
        pacc_reg   <= pacc_next;
        pmod_reg   <= pmod_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        tmp_reg    <= tmp_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/rmce_checker.sv
// ----------------------------------------------------------------------------
// rmce_checker
// port-level checks of the rsa mod-exp engine, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmce_checker import rmce_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input logic         result_valid,
    input logic         result_stall,
    input rmce_result_t result
);

    // a stalled result word holds
    `RMCE_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // engine is busy right after taking a word
    `RMCE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall)

    // no result can show up the cycle after a word is taken
    `RMCE_ASSERT_NXT(a_no_instant_result, clk, rst_n, item_valid && !item_stall, !$rose(result_valid))

    // a fresh result comes with the engine back in idle
    `RMCE_ASSERT_IMP(a_idle_with_result, clk, rst_n, $rose(result_valid), !item_stall)

endmodule

bind rsa_modexp_crt_engine rmce_checker u_rmce_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rsa mod-exp engine with crt path
// feeds words through a queue-driven driver, predicts each result from a
// local copy of the key registers and compares every result word in order
// ----------------------------------------------------------------------------
module tb_top;
    import rmce_pkg::*;

    localparam int         CYCLE_LIMIT = 4_000_000;
    localparam int         HOLD_CYCLES = 3000;
    localparam rmce_word_t LOW_HALF    = 64'h0000_0000_FFFF_FFFF;
    localparam rmce_word_t ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    // local copy of the key registers
    typedef struct {
        rmce_word_t n;
        rmce_word_t e;
        rmce_word_t p;
        rmce_word_t q;
        rmce_word_t dp;
        rmce_word_t dq;
        rmce_word_t qi;
    } key_set_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    item_valid = 1'b0;
    logic                    item_stall;
    rmce_item_t              item = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    rmce_result_t            result;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    rmce_word_t              cfg_data = '0;

    key_set_t     keys = '{default: '0};
    rmce_item_t   pending_words[$];
    rmce_result_t expected_results[$];
    int           outstanding = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           hold_token = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    rsa_modexp_crt_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // modular arithmetic of the engine, 64-bit wraparound as in hardware
    // ------------------------------------------------------------------------

    // a zero modulus leaves the value untouched
    function automatic rmce_word_t mod_reduce(rmce_word_t a, rmce_word_t m);
        return (m != 0) ? a % m : a;
    endfunction

    // overflow-free add: compare against the gap to m instead of summing
    function automatic rmce_word_t mod_add(rmce_word_t a, rmce_word_t b, rmce_word_t m);
        rmce_word_t ra, rb, gap;
        ra  = mod_reduce(a, m);
        rb  = mod_reduce(b, m);
        gap = m - rb;
        return (ra >= gap) ? ra - gap : ra + rb;
    endfunction

    function automatic rmce_word_t mod_sub(rmce_word_t a, rmce_word_t b, rmce_word_t m);
        rmce_word_t ra, rb;
        ra = mod_reduce(a, m);
        rb = mod_reduce(b, m);
        return (ra < rb) ? ra + (m - rb) : ra - rb;
    endfunction

    // add-and-double product
    function automatic rmce_word_t mod_mul(rmce_word_t a, rmce_word_t b, rmce_word_t m);
        rmce_word_t acc, x, y;
        acc = '0;
        x   = a;
        y   = b;
        while (y != 0)
        begin
            if (y[0])
                acc = mod_add(acc, x, m);
            y = y >> 1;
            x = mod_add(x, x, m);
        end
        return acc;
    endfunction

    // right-to-left square-and-multiply; exponent 0 gives 1 unreduced
    function automatic rmce_word_t mod_pow(rmce_word_t base, rmce_word_t e, rmce_word_t m);
        rmce_word_t acc, x, y;
        acc = 64'd1;
        x   = base;
        y   = e;
        while (y != 0)
        begin
            if (y[0])
                acc = mod_mul(acc, x, m);
            y = y >> 1;
            x = mod_mul(x, x, m);
        end
        return acc;
    endfunction

    function automatic rmce_result_t modexp_predict(rmce_item_t it, key_set_t k);
        rmce_result_t r;
        rmce_word_t   m1, m2, h, y;
        if (it.value_in >= k.n)
        begin
            // range error: word passes through unchanged
            r.value_out = it.value_in;
            r.error     = 1'b1;
        end
        else
        begin
            if (it.command == CMD_PLAIN)
                y = mod_pow(it.value_in, k.e, k.n);
            else
            begin
                m1 = mod_pow(it.value_in, k.dp, k.p);
                m2 = mod_pow(it.value_in, k.dq, k.q);
                h  = mod_mul(k.qi, mod_sub(m1, m2, k.p), k.p);
                y  = m2 + h * k.q;
            end
            r.value_out = y;
            r.error     = (y >= k.n);
        end
        return r;
    endfunction

    // extended euclid, only for building a consistent large key
    function automatic longint inv_mod(longint a, longint m);
        longint t, nt, r, nr, qt, tmp;
        t  = 0;
        nt = 1;
        r  = m;
        nr = a % m;
        while (nr != 0)
        begin
            qt  = r / nr;
            tmp = t - qt * nt;
            t   = nt;
            nt  = tmp;
            tmp = r - qt * nr;
            r   = nr;
            nr  = tmp;
        end
        if (t < 0)
            t = t + m;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------

    function automatic rmce_word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic rmce_word_t rand_bits(int len);
        rmce_word_t w;
        w = rand_word();
        return (len == 0) ? '0 : w >> (64 - len);
    endfunction

    // short exponent most of the time, now and then a full-width one
    function automatic int exp_len(int full);
        return ($urandom_range(0, 7) == 0) ? full : $urandom_range(0, 12);
    endfunction

    // junk in the upper half of a 32-bit register write
    function automatic rmce_word_t with_junk(rmce_word_t w);
        logic [31:0] hi;
        hi = $urandom_range(0, 1) ? $urandom() : 32'd0;
        return {hi, w[31:0]};
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else if (r < 98)
            return $urandom_range(5, 40);
        else
            return $urandom_range(41, 200);
    endfunction

    task automatic report_mismatch(string what, rmce_word_t got, rmce_word_t want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // input driver: one word at a time from the pending queue
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic       next_valid;
        rmce_item_t next_item;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            next_valid = item_valid;
            next_item  = item;
            // word taken: predict it now, with the keys in force
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(modexp_predict(item, keys));
                next_valid = 1'b0;
                send_gap   = pick_gap();
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_words.size() > 0)
                begin
                    next_item  = pending_words.pop_front();
                    next_valid = 1'b1;
                end
            end
            // single update per edge keeps valid high across back-to-back words
            item_valid <= next_valid;
            item       <= next_item;
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted on its own when the stimulus asks
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // result monitor and stall generator
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rmce_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result word with nothing pending", result.value_out, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.value_out !== want.value_out)
                        report_mismatch("value_out", result.value_out, want.value_out);
                    if (result.error !== want.error)
                        report_mismatch("error", {63'd0, result.error}, {63'd0, want.error});
                end
                if (outstanding > 0)
                    outstanding--;
            end
            // random short or long stalls, on top of any long hold-off
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0 || hold_left > 0)
            begin
                if (stall_left > 0)
                    stall_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequencing
    // ------------------------------------------------------------------------

    task automatic add_item(logic cmd, rmce_word_t value);
        rmce_item_t it;
        it.command  = cmd;
        it.value_in = value;
        pending_words.push_back(it);
        outstanding++;
    endtask

    // returns once every queued word has produced its result
    task automatic wait_drain();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write; caller lowers valid after the last one
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, rmce_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MODULUS_N: keys.n  = data;
            REG_EXPONENT:  keys.e  = data;
            REG_PRIME_P:   keys.p  = data & LOW_HALF;
            REG_PRIME_Q:   keys.q  = data & LOW_HALF;
            REG_EXP_MOD_P: keys.dp = data & LOW_HALF;
            REG_EXP_MOD_Q: keys.dq = data & LOW_HALF;
            REG_Q_INVERSE: keys.qi = data & LOW_HALF;
            default: ;
        endcase
    endtask

    task automatic load_keys(rmce_word_t n, rmce_word_t e, rmce_word_t p, rmce_word_t q,
                             rmce_word_t dp, rmce_word_t dq, rmce_word_t qi);
        write_reg(REG_MODULUS_N, n);
        write_reg(REG_EXPONENT, e);
        write_reg(REG_PRIME_P, p);
        write_reg(REG_PRIME_Q, q);
        write_reg(REG_EXP_MOD_P, dp);
        write_reg(REG_EXP_MOD_Q, dq);
        write_reg(REG_Q_INVERSE, qi);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rmce_word_t big_p, big_q, big_n, big_dp, big_dq, big_qi, cipher;
        rmce_word_t n_r, p_r, q_r, v_r;
        int         pick;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // keys still at reset: modulus 0, every word is out of range
        add_item(CMD_PLAIN, '0);
        add_item(CMD_CRT, ALL_ONES);
        wait_drain();

        // small textbook key, consistent crt parameters
        load_keys(64'd3233, 64'd17, 64'd61, 64'd53, 64'd53, 64'd49, 64'd38);
        add_item(CMD_PLAIN, 64'd65);
        add_item(CMD_CRT, 64'd2790);
        add_item(CMD_PLAIN, 64'd0);
        add_item(CMD_PLAIN, 64'd3232);
        add_item(CMD_CRT, 64'd3233);
        add_item(CMD_CRT, 64'd0);
        add_item(CMD_CRT, 64'd3232);
        wait_drain();

        // largest 32-bit primes, modulus near the top of the word
        big_p  = 64'd4294967291;
        big_q  = 64'd4294967279;
        big_n  = big_p * big_q;
        big_dp = rmce_word_t'(inv_mod(65537, longint'(big_p) - 1));
        big_dq = rmce_word_t'(inv_mod(65537, longint'(big_q) - 1));
        big_qi = rmce_word_t'(inv_mod(longint'(big_q), longint'(big_p)));
        cipher = mod_pow(64'd123456789, 64'd65537, big_n);
        load_keys(big_n, 64'd65537, big_p, big_q, big_dp, big_dq, big_qi);
        add_item(CMD_PLAIN, big_n - 1);
        add_item(CMD_CRT, cipher);
        add_item(CMD_PLAIN, 64'd2);
        add_item(CMD_CRT, ALL_ONES);
        wait_drain();

        // every register at its maximum
        load_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        add_item(CMD_PLAIN, ALL_ONES - 1);
        add_item(CMD_CRT, 64'h8000_0000_0000_0000);
        add_item(CMD_PLAIN, ALL_ONES);
        wait_drain();

        // zero exponents with n of 1, zero primes: power gives 1 and flags it
        load_keys(64'd1, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        add_item(CMD_PLAIN, 64'd0);
        add_item(CMD_CRT, 64'd0);
        add_item(CMD_PLAIN, 64'd1);
        wait_drain();

        // zero p with inconsistent keys: wrapped recombination
        load_keys(ALL_ONES, 64'd3, 64'd0, 64'd12345, 64'd7, 64'h1F, LOW_HALF);
        add_item(CMD_CRT, rand_word() >> 1);
        add_item(CMD_CRT, rand_word() | 64'd1);
        wait_drain();

        // receiver holds off while words keep coming, so the engine backs up
        load_keys(64'd3233, 64'd5, 64'd61, 64'd53, 64'd53, 64'd49, 64'd38);
        hold_token <= hold_token + 1;
        for (int i = 0; i < 8; i++)
            add_item(CMD_PLAIN, rmce_word_t'($urandom_range(0, 3232)));
        wait_drain();

        // random key sets, ten words each
        for (int ph = 0; ph < 7; ph++)
        begin
            p_r  = ($urandom_range(0, 7) == 0) ? '0 : rmce_word_t'($urandom());
            q_r  = ($urandom_range(0, 7) == 0) ? '0 : rmce_word_t'($urandom());
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1:    n_r = rand_word();
                2, 3:    n_r = rmce_word_t'($urandom_range(2, 65535));
                4, 5:    n_r = p_r * q_r;
                6:       n_r = ALL_ONES;
                7:       n_r = 64'd1;
                default: n_r = rand_word() | 64'h8000_0000_0000_0000;
            endcase
            load_keys(n_r, rand_bits(exp_len(64)), with_junk(p_r), with_junk(q_r),
                      with_junk(rand_bits(exp_len(32))), with_junk(rand_bits(exp_len(32))),
                      with_junk(rmce_word_t'($urandom())));
            for (int i = 0; i < 10; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7 && n_r != 0)
                    v_r = rand_word() % n_r;
                else if (pick == 7)
                    v_r = n_r;
                else
                    v_r = rand_word();
                add_item(logic'($urandom_range(0, 1)), v_r);
            end
            wait_drain();
        end

        repeat (50) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", rmce_word_t'(expected_results.size()), '0);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
